@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of the decimal formatter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define FPDF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define FPDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/fpdf_pkg.sv @@
// Package with the types and constants of the fixed-point decimal formatter.
`default_nettype none

package fpdf_pkg;

    localparam int VALUE_W       = 15;
    localparam int PLACES_W      = 3;
    localparam int CHAR_W        = 7;
    localparam int DIGIT_W       = 4;
    localparam int NUM_DIV       = 4;
    localparam int NUM_DIGITS    = 5;
    localparam int POS_W         = 3;
    localparam int MAX_PLACES    = 5;
    localparam int MAX_OUT       = 7;
    localparam int BUFFER_LENGTH_DEF = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_POINT = 7'h2E;

    // Division by ten as a multiply by 2^19/10 rounded up; exact below 43690.
    localparam logic [15:0] RECIP_10    = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [PLACES_W-1:0] decimal_places;
    } t_in;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [VALUE_W-1:0]                rest;
        logic [PLACES_W-1:0]               places;
        logic [NUM_DIV-1:0][DIGIT_W-1:0]   digits;
    } t_work;

endpackage

`default_nettype wire

@@ src/fpdf_div_stage.sv @@
// One pipeline stage that splits off the next decimal digit of the value.
`default_nettype none

module fpdf_div_stage #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  fpdf_pkg::t_work i_work,
    output logic           o_valid,
    output fpdf_pkg::t_work o_work
);
    import fpdf_pkg::*;

    localparam int PROD_W = VALUE_W + 16;

    logic [PROD_W-1:0]  prod;
    logic [VALUE_W-1:0] quo;
    logic [VALUE_W-1:0] rem;
    t_work              n_work;
    logic               r_valid;
    t_work              r_work;

    always_comb begin
        prod   = PROD_W'(i_work.rest) * PROD_W'(RECIP_10);
        quo    = VALUE_W'(prod >> RECIP_SHIFT);
        rem    = i_work.rest - ((quo << 3) + (quo << 1));
        n_work = i_work;
        n_work.rest        = quo;
        n_work.digits[IDX] = rem[DIGIT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

`default_nettype wire

@@ src/fpdf_serializer.sv @@
// Character serializer: loads the digits of one value and emits its text.
`default_nettype none

module fpdf_serializer #(
    parameter int BUFFER_LENGTH = fpdf_pkg::BUFFER_LENGTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  fpdf_pkg::t_work i_work,
    output logic            o_take,
    output logic            o_strobe,
    output fpdf_pkg::t_out  o_result
);
    import fpdf_pkg::*;

    localparam int CAP_RAW = BUFFER_LENGTH - 1;
    localparam int CAP     = (CAP_RAW > MAX_OUT) ? MAX_OUT : CAP_RAW;
    localparam logic [POS_W-1:0] CAP_L = POS_W'(CAP);
    localparam int PAD_W   = ((1 << POS_W) - NUM_DIGITS) * DIGIT_W;

    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]     ld_dig;
    logic [POS_W-1:0]                       ndig;
    logic [POS_W-1:0]                       len_a;
    logic [POS_W-1:0]                       len_b;
    logic [POS_W-1:0]                       len;
    logic [POS_W-1:0]                       cnt;
    logic [(1 << POS_W)-1:0][DIGIT_W-1:0]   dig8;
    logic [POS_W-1:0]                       idx;
    logic                                   load;

    logic                                   r_act;
    logic [POS_W-1:0]                       r_pos;
    logic [PLACES_W-1:0]                    r_places;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]     r_dig;

    // The text is max(places + 2, significant digits + 1) characters long,
    // and only its rightmost characters up to the buffer capacity are sent.
    always_comb begin
        ld_dig = {i_work.rest[DIGIT_W-1:0], i_work.digits};
        ndig   = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (ld_dig[i] != '0) begin
                ndig = POS_W'(i + 1);
            end
        end
        len_a = POS_W'(i_work.places) + POS_W'(2);
        len_b = ndig + POS_W'(1);
        len   = (len_a > len_b) ? len_a : len_b;
        cnt   = (len > CAP_L) ? CAP_L : len;
    end

    assign o_take = !r_act || (r_pos == '0);
    assign load   = i_valid && o_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (load) begin
            r_act <= 1'b1;
        end else if (r_act && (r_pos == '0)) begin
            r_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pos    <= cnt - POS_W'(1);
            r_places <= i_work.places;
            r_dig    <= ld_dig;
        end else if (r_act && (r_pos != '0)) begin
            r_pos <= r_pos - POS_W'(1);
        end
    end

    // Position counts from the right: fraction digits, then the point, then
    // the integer digits. A zero integer part reads as the digit above the
    // point, which is zero, so the leading '0' needs no special path.
    always_comb begin
        dig8 = {{PAD_W{1'b0}}, r_dig};
        idx  = (r_pos < POS_W'(r_places)) ? r_pos : (r_pos - POS_W'(1));
        if (r_pos == POS_W'(r_places)) begin
            o_result.character = ASCII_POINT;
        end else begin
            o_result.character = ASCII_ZERO + CHAR_W'(dig8[idx]);
        end
        o_result.last = (r_pos == '0);
    end

    assign o_strobe = r_act;

endmodule

`default_nettype wire

@@ src/fixed_point_decimal_formatter_core.sv @@
// Top level of the fixed-point decimal formatter: input stage, digit pipeline, serializer.
//
//  Channel   Handshake                     Beat
//  input     start high while busy low     i_item  (value, decimal_places)
//  result    o_strobe high per beat        o_result (character, last)
//
// An item passes an input register and four digit stages, one digit per
// stage, and is registered in each before it reaches the serializer.
// The serializer sends one character per cycle, two to seven per item at the
// default buffer length, and holds an item until its last character is sent.
// Up to five items wait in the input register and the digit stages; busy rises
// only while the last stage holds an item that the serializer cannot yet take.
// Reset clears all valid bits and the serializer; the receiver never stalls.
`default_nettype none

module fixed_point_decimal_formatter_core #(
    parameter int BUFFER_LENGTH = fpdf_pkg::BUFFER_LENGTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  fpdf_pkg::t_in   i_item,
    output logic            o_strobe,
    output fpdf_pkg::t_out  o_result
);
    import fpdf_pkg::*;

    logic   adv;
    logic   take;
    logic   accept;
    t_work  n_w0;
    logic   r_v0;
    t_work  r_w0;
    logic   v [NUM_DIV+1];
    t_work  w [NUM_DIV+1];

    // The whole pipeline shifts together unless its last stage is stuck.
    assign adv    = !v[NUM_DIV] || take;
    assign busy   = !adv;
    assign accept = start && !busy;

    always_comb begin
        n_w0        = '0;
        n_w0.rest   = i_item.value;
        n_w0.places = (i_item.decimal_places > PLACES_W'(MAX_PLACES)) ?
                      PLACES_W'(MAX_PLACES) : i_item.decimal_places;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w0 <= n_w0;
        end
    end

    assign v[0] = r_v0;
    assign w[0] = r_w0;

    for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
        fpdf_div_stage #(
            .IDX(g)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (v[g]),
            .i_work  (w[g]),
            .o_valid (v[g+1]),
            .o_work  (w[g+1])
        );
    end

    fpdf_serializer #(
        .BUFFER_LENGTH(BUFFER_LENGTH)
    ) u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (v[NUM_DIV]),
        .i_work   (w[NUM_DIV]),
        .o_take   (take),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

@@ src/fpdf_checker.sv @@
// Port-level checker for the decimal formatter and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module fpdf_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            busy,
    input  fpdf_pkg::t_out  o_result,
    input  logic            o_strobe
);
    import fpdf_pkg::*;

    // Reset leaves the block idle and silent.
    `FPDF_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!busy && !o_strobe), "not idle after reset")

    // Every character is a decimal digit or the point.
    `FPDF_ASSERT(a_char_legal, i_clk, i_rst_n, o_strobe |-> ((o_result.character >= ASCII_ZERO && o_result.character <= ASCII_ZERO + 7'd9) || o_result.character == ASCII_POINT), "illegal character")

    // A text is sent without gaps: a character that is not last is followed by another.
    `FPDF_ASSERT(a_no_gap, i_clk, i_rst_n, (o_strobe && !o_result.last) |=> o_strobe, "gap inside a text")

    // A point that is not the last character is followed by a digit.
    `FPDF_ASSERT(a_point_once, i_clk, i_rst_n, (o_strobe && o_result.character == ASCII_POINT && !o_result.last) |=> (o_result.character != ASCII_POINT), "two points in a row")

endmodule

bind fixed_point_decimal_formatter_core fpdf_checker u_fpdf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_result (o_result),
    .o_strobe (o_strobe)
);

`default_nettype wire
